### hdl/msa_pkg.sv
package msa_pkg;

  // Sizes of the region arithmetic and of the mark stacks
  localparam int unsigned WORD_W         = 32;
  localparam int unsigned MARK_DEPTH     = 16;
  localparam int unsigned ALIGN_BYTES    = 8;
  localparam int unsigned HEADER_BYTES   = 64;
  localparam int unsigned BLOCK_BYTES    = 16;
  localparam int unsigned MIN_HEAP_BYTES = 256;
  localparam int unsigned ADDR_BITS      = 32;
  localparam int unsigned RESET_HEAP     = 65536;

  // Field widths
  localparam int unsigned MODE_W   = 4;
  localparam int unsigned KEY_W    = 5;
  localparam int unsigned STATUS_W = 3;

  // Derived widths
  localparam int unsigned DEPTH_W = $clog2(MARK_DEPTH + 1);
  localparam int unsigned IDX_W   = (MARK_DEPTH > 1) ? $clog2(MARK_DEPTH) : 1;
  localparam int unsigned CMP_W   = (DEPTH_W > KEY_W) ? DEPTH_W : KEY_W;

  localparam logic [WORD_W-1:0] ALIGN_MASK = ~WORD_W'(ALIGN_BYTES - 1);
  localparam logic [WORD_W-1:0] ADDR_MASK  =
    (ADDR_BITS >= WORD_W) ? {WORD_W{1'b1}} : WORD_W'((64'd1 << ADDR_BITS) - 64'd1);

  typedef enum logic [MODE_W-1:0] {
    MODE_INIT        = 4'd0,
    MODE_ALLOC_TOP   = 4'd1,
    MODE_ALLOC_BOT   = 4'd2,
    MODE_KEYED_TOP   = 4'd3,
    MODE_KEYED_BOT   = 4'd4,
    MODE_MARK_TOP    = 4'd5,
    MODE_MARK_BOT    = 4'd6,
    MODE_RELEASE_TOP = 4'd7,
    MODE_RELEASE_BOT = 4'd8
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_NO_SPACE   = 3'd1,
    ST_STACK_FULL = 3'd2,
    ST_UNBALANCED = 3'd3,
    ST_RELEASED   = 3'd4,
    ST_NOT_MARKED = 3'd5
  } status_t;

  typedef enum logic {
    FSM_IDLE,
    FSM_EXEC
  } fsm_state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;  // take the request fields
    logic execute;  // apply the operation and load the result register
  } dp_cmd_t;

  // Mark stack depths, observed by the checks in the top level
  typedef struct packed {
    logic [DEPTH_W-1:0] top_depth;
    logic [DEPTH_W-1:0] bottom_depth;
  } dp_depths_t;

endpackage

### hdl/msa_ifs.sv
interface msa_req_if;
  import msa_pkg::*;
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [WORD_W-1:0]   request_bytes;
  logic [KEY_W-1:0]    key_in;

  modport source (output valid, mode, request_bytes, key_in, input ready);
  modport sink   (input valid, mode, request_bytes, key_in, output ready);
endinterface

interface msa_rsp_if;
  import msa_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [WORD_W-1:0]   address;
  logic [KEY_W-1:0]    key_out;
  logic [WORD_W-1:0]   used_bytes;
  logic [WORD_W-1:0]   free_bytes;

  modport source (output valid, status, address, key_out, used_bytes, free_bytes,
                  input ready);
  modport sink   (input valid, status, address, key_out, used_bytes, free_bytes,
                  output ready);
endinterface

### hdl/msa_ctrl.sv
module msa_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output msa_pkg::dp_cmd_t cmd
);
  import msa_pkg::*;

  fsm_state_t state, state_next;
  logic       out_valid_next;

  // State register and result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= FSM_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state: an operation runs once the result register is free
  always_comb begin
    state_next = state;
    unique case (state)
      FSM_IDLE: begin
        if (in_valid) state_next = FSM_EXEC;
      end
      FSM_EXEC: begin
        if (!out_valid || out_ready) state_next = FSM_IDLE;
      end
      default: state_next = FSM_IDLE;
    endcase
  end

  // Outputs and commands
  always_comb begin
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    unique case (state)
      FSM_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      FSM_EXEC: begin
        cmd.execute = !out_valid || out_ready;
      end
      default: ;
    endcase
  end

  // The result stays valid until its transfer, unless a new one replaces it
  always_comb begin
    if (cmd.execute) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

### hdl/msa_dp.sv
module msa_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [msa_pkg::WORD_W-1:0]     cfg_data,
  input  msa_pkg::dp_cmd_t               cmd,
  input  logic [msa_pkg::MODE_W-1:0]     mode,
  input  logic [msa_pkg::WORD_W-1:0]     request_bytes,
  input  logic [msa_pkg::KEY_W-1:0]      key_in,
  output logic [msa_pkg::STATUS_W-1:0]   status,
  output logic [msa_pkg::WORD_W-1:0]     address,
  output logic [msa_pkg::KEY_W-1:0]      key_out,
  output logic [msa_pkg::WORD_W-1:0]     used_bytes,
  output logic [msa_pkg::WORD_W-1:0]     free_bytes,
  output msa_pkg::dp_depths_t            depths
);
  import msa_pkg::*;

  // Captured request
  logic [MODE_W-1:0] r_mode;
  logic [WORD_W-1:0] r_bytes;
  logic [KEY_W-1:0]  r_key;

  // Allocator state
  logic [WORD_W-1:0]  heap_size;
  logic [WORD_W-1:0]  low_pointer, low_pointer_next;
  logic [WORD_W-1:0]  free_span, free_span_next;
  logic [WORD_W-1:0]  bytes_used, bytes_used_next;
  logic [WORD_W-1:0]  total_bytes, total_bytes_next;
  logic [DEPTH_W-1:0] top_depth, top_depth_next;
  logic [DEPTH_W-1:0] bottom_depth, bottom_depth_next;
  logic [WORD_W-1:0]  top_marks [MARK_DEPTH];
  logic [WORD_W-1:0]  bottom_marks [MARK_DEPTH];

  logic [STATUS_W-1:0] status_next;
  logic [WORD_W-1:0]   addr_next;
  logic [KEY_W-1:0]    kout_next;
  logic                push_top, push_bottom;

  // Top allocation terms
  logic [WORD_W-1:0] at_new;
  logic              at_fail;
  // Bottom allocation terms
  logic [WORD_W:0]   ab_taken;
  logic              ab_fail;
  // Release terms
  logic [DEPTH_W-1:0] top_dec, bottom_dec;
  logic [WORD_W-1:0]  top_mark_rd, bottom_mark_rd;
  logic [WORD_W-1:0]  span_end;
  logic [WORD_W-1:0]  rt_span, rb_span;
  logic [STATUS_W-1:0] top_key_st, bottom_key_st;
  logic [STATUS_W-1:0] top_rel_st, bottom_rel_st;

  function automatic logic [STATUS_W-1:0] rel_check(
    input logic [DEPTH_W-1:0] depth,
    input logic [KEY_W-1:0]   key
  );
    logic [CMP_W-1:0] d;
    logic [CMP_W-1:0] k;
    d = CMP_W'(depth);
    k = CMP_W'(key);
    if (k > d) begin
      return ST_UNBALANCED;
    end else if (k < d) begin
      return ST_RELEASED;
    end
    return ST_OK;
  endfunction

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      r_mode  <= mode;
      r_bytes <= request_bytes;
      r_key   <= key_in;
    end
  end

  // Top allocation: the new span is the remainder rounded down
  assign at_new  = (free_span - r_bytes) & ALIGN_MASK;
  assign at_fail = (r_bytes == '0) || (free_span < r_bytes) ||
                   (at_new < WORD_W'(BLOCK_BYTES));

  // Bottom allocation: the request is rounded up
  assign ab_taken = ({1'b0, r_bytes} + (WORD_W + 1)'(ALIGN_BYTES - 1)) &
                    {1'b1, ALIGN_MASK};
  assign ab_fail  = (r_bytes == '0) ||
                    (({1'b0, ab_taken} + (WORD_W + 2)'(BLOCK_BYTES)) >
                     {2'b00, free_span});

  // Latest marks and the spans a release restores
  assign top_dec        = top_depth - 1'b1;
  assign bottom_dec     = bottom_depth - 1'b1;
  assign top_mark_rd    = top_marks[top_dec[IDX_W-1:0]];
  assign bottom_mark_rd = bottom_marks[bottom_dec[IDX_W-1:0]];
  assign span_end       = low_pointer + free_span;
  assign rt_span        = top_mark_rd - low_pointer;
  assign rb_span        = span_end - bottom_mark_rd;

  assign top_rel_st    = rel_check(top_depth, r_key);
  assign bottom_rel_st = rel_check(bottom_depth, r_key);
  assign top_key_st    = (top_depth == '0) ? ST_NOT_MARKED : top_rel_st;
  assign bottom_key_st = (bottom_depth == '0) ? ST_NOT_MARKED : bottom_rel_st;

  // Operation decode and state update
  always_comb begin
    low_pointer_next  = low_pointer;
    free_span_next    = free_span;
    bytes_used_next   = bytes_used;
    total_bytes_next  = total_bytes;
    top_depth_next    = top_depth;
    bottom_depth_next = bottom_depth;
    status_next       = ST_OK;
    addr_next         = '0;
    kout_next         = '0;
    push_top          = 1'b0;
    push_bottom       = 1'b0;
    unique case (mode_t'(r_mode)) inside
      MODE_INIT: begin
        if (heap_size < WORD_W'(MIN_HEAP_BYTES) || heap_size < WORD_W'(HEADER_BYTES)) begin
          status_next = ST_NO_SPACE;
        end else begin
          total_bytes_next  = heap_size;
          low_pointer_next  = WORD_W'(HEADER_BYTES);
          bytes_used_next   = WORD_W'(HEADER_BYTES);
          free_span_next    = heap_size - WORD_W'(HEADER_BYTES);
          top_depth_next    = '0;
          bottom_depth_next = '0;
        end
      end
      MODE_ALLOC_TOP, MODE_KEYED_TOP: begin
        if (mode_t'(r_mode) == MODE_KEYED_TOP && top_key_st != ST_OK) begin
          status_next = top_key_st;
        end else if (at_fail) begin
          status_next = ST_NO_SPACE;
        end else begin
          bytes_used_next = bytes_used + (free_span - at_new);
          free_span_next  = at_new;
          addr_next       = low_pointer + at_new;
        end
      end
      MODE_ALLOC_BOT, MODE_KEYED_BOT: begin
        if (mode_t'(r_mode) == MODE_KEYED_BOT && bottom_key_st != ST_OK) begin
          status_next = bottom_key_st;
        end else if (ab_fail) begin
          status_next = ST_NO_SPACE;
        end else begin
          addr_next        = low_pointer;
          low_pointer_next = low_pointer + ab_taken[WORD_W-1:0];
          free_span_next   = free_span - ab_taken[WORD_W-1:0];
          bytes_used_next  = bytes_used + ab_taken[WORD_W-1:0];
        end
      end
      MODE_MARK_TOP: begin
        if (top_depth < DEPTH_W'(MARK_DEPTH)) begin
          push_top       = 1'b1;
          top_depth_next = top_depth + 1'b1;
          kout_next      = KEY_W'(top_depth_next);
        end else begin
          status_next = ST_STACK_FULL;
        end
      end
      MODE_MARK_BOT: begin
        if (bottom_depth < DEPTH_W'(MARK_DEPTH)) begin
          push_bottom       = 1'b1;
          bottom_depth_next = bottom_depth + 1'b1;
          kout_next         = KEY_W'(bottom_depth_next);
        end else begin
          status_next = ST_STACK_FULL;
        end
      end
      MODE_RELEASE_TOP: begin
        // An empty stack releases nothing and reports success
        if (top_depth != '0) begin
          status_next = top_rel_st;
          if (top_rel_st == ST_OK) begin
            top_depth_next  = top_dec;
            bytes_used_next = bytes_used - (rt_span - free_span);
            free_span_next  = rt_span;
          end
        end
      end
      MODE_RELEASE_BOT: begin
        if (bottom_depth != '0) begin
          status_next = bottom_rel_st;
          if (bottom_rel_st == ST_OK) begin
            bottom_depth_next = bottom_dec;
            bytes_used_next   = bytes_used - (rb_span - free_span);
            low_pointer_next  = bottom_mark_rd;
            free_span_next    = rb_span;
          end
        end
      end
      default: begin
        status_next = ST_NO_SPACE;
      end
    endcase
  end

  // Configuration register and allocator state
  always_ff @(posedge clk) begin
    if (rst) begin
      heap_size    <= WORD_W'(RESET_HEAP);
      low_pointer  <= WORD_W'(HEADER_BYTES);
      free_span    <= WORD_W'(RESET_HEAP - HEADER_BYTES);
      bytes_used   <= WORD_W'(HEADER_BYTES);
      total_bytes  <= WORD_W'(RESET_HEAP);
      top_depth    <= '0;
      bottom_depth <= '0;
    end else begin
      if (cfg_we) heap_size <= cfg_data;
      if (cmd.execute) begin
        low_pointer  <= low_pointer_next;
        free_span    <= free_span_next;
        bytes_used   <= bytes_used_next;
        total_bytes  <= total_bytes_next;
        top_depth    <= top_depth_next;
        bottom_depth <= bottom_depth_next;
      end
    end
  end

  // Mark stacks, written at the current depth
  always_ff @(posedge clk) begin
    if (cmd.execute && push_top) begin
      top_marks[top_depth[IDX_W-1:0]] <= span_end;
    end
    if (cmd.execute && push_bottom) begin
      bottom_marks[bottom_depth[IDX_W-1:0]] <= low_pointer;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      status     <= status_next;
      address    <= (status_next == ST_OK) ? (addr_next & ADDR_MASK) : '0;
      key_out    <= kout_next;
      used_bytes <= bytes_used_next;
      free_bytes <= total_bytes_next - bytes_used_next;
    end
  end

  assign depths.top_depth    = top_depth;
  assign depths.bottom_depth = bottom_depth;

endmodule

### hdl/mark_release_stack_allocator.sv
// Channel | Modport | Moves
// --------+---------+-----------------------------------------------------
// req     | sink    | mode, request_bytes, key_in
// rsp     | source  | status, address, key_out, used_bytes, free_bytes
//
// Each request is captured in FSM_IDLE; then, in FSM_EXEC, the
// datapath applies the operation and loads the result register.
// A new request is taken while the previous result still waits on rsp.
// A waiting result stalls the next operation only until its transfer.
// Synchronous reset restores the region to the reset heap_size.
module mark_release_stack_allocator (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [msa_pkg::WORD_W-1:0] cfg_data,
  msa_req_if.sink                    req,
  msa_rsp_if.source                  rsp
);
  import msa_pkg::*;

  dp_cmd_t    cmd;
  dp_depths_t depths;

  // Sequencing of captures, operations and result transfers
  msa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd)
  );

  // Region state, mark stacks and result register
  msa_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .mode          (req.mode),
    .request_bytes (req.request_bytes),
    .key_in        (req.key_in),
    .status        (rsp.status),
    .address       (rsp.address),
    .key_out       (rsp.key_out),
    .used_bytes    (rsp.used_bytes),
    .free_bytes    (rsp.free_bytes),
    .depths        (depths)
  );

`ifndef SYNTHESIS
  // Only one request is held at a time
  a_one_held: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request taken while another is being processed");

  // An executed operation always presents its result
  a_exec_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.execute |=> rsp.valid)
    else $error("result not presented after execution");

  // A transferred result is withdrawn unless a new one replaced it
  a_drop_after: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.ready && !cmd.execute) |=> !rsp.valid)
    else $error("result repeated after its transfer");

  // Mark stack depths stay within the stack size
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    (depths.top_depth <= DEPTH_W'(MARK_DEPTH)) &&
    (depths.bottom_depth <= DEPTH_W'(MARK_DEPTH)))
    else $error("mark stack depth out of range");
`endif

endmodule

### tb/tb_top.sv
module tb_top;
  import msa_pkg::*;

  localparam int unsigned CYCLE       = 20;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_ITEMS = 205;

  // One expected response of the allocator.
  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [WORD_W-1:0]   address;
    logic [KEY_W-1:0]    key_out;
    logic [WORD_W-1:0]   used;
    logic [WORD_W-1:0]   free;
  } alloc_result_t;

  // Tracks the region and both mark stacks, and holds the responses still owed.
  class alloc_scoreboard;
    logic [WORD_W-1:0] heap_cfg;
    logic [WORD_W-1:0] low_ptr;
    logic [WORD_W-1:0] span;
    logic [WORD_W-1:0] used;
    logic [WORD_W-1:0] total;
    int unsigned       top_depth;
    int unsigned       bot_depth;
    logic [WORD_W-1:0] top_marks [MARK_DEPTH];
    logic [WORD_W-1:0] bot_marks [MARK_DEPTH];
    alloc_result_t     owed_results [$];
    int unsigned       n_errors;
    int unsigned       n_checked;
    int unsigned       status_seen [8];

    function new();
      heap_cfg  = RESET_HEAP;
      low_ptr   = HEADER_BYTES;
      span      = RESET_HEAP - HEADER_BYTES;
      used      = HEADER_BYTES;
      total     = RESET_HEAP;
      top_depth = 0;
      bot_depth = 0;
      n_errors  = 0;
      n_checked = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function int unsigned pending();
      return owed_results.size();
    endfunction

    // Carve bytes off the upper end of the free span.
    function status_t take_top(logic [WORD_W-1:0] n, output logic [WORD_W-1:0] a);
      logic [WORD_W-1:0] new_span;
      a = '0;
      if (n == 0 || span < n) return ST_NO_SPACE;
      new_span = (span - n) & ~WORD_W'(ALIGN_BYTES - 1);
      if (new_span < BLOCK_BYTES) return ST_NO_SPACE;
      used += span - new_span;
      span  = new_span;
      a     = low_ptr + span;
      return ST_OK;
    endfunction

    // Carve the rounded-up request off the lower end of the free span.
    function status_t take_bottom(logic [WORD_W-1:0] n, output logic [WORD_W-1:0] a);
      logic [WORD_W:0] taken;
      a = '0;
      if (n == 0) return ST_NO_SPACE;
      taken = ({1'b0, n} + (WORD_W + 1)'(ALIGN_BYTES - 1)) & ~(WORD_W + 1)'(ALIGN_BYTES - 1);
      if (taken + (WORD_W + 1)'(BLOCK_BYTES) > {1'b0, span}) return ST_NO_SPACE;
      a        = low_ptr;
      low_ptr += taken[WORD_W-1:0];
      span    -= taken[WORD_W-1:0];
      used    += taken[WORD_W-1:0];
      return ST_OK;
    endfunction

    // Key against the current depth; a keyed allocation also needs a mark.
    function status_t key_status(int unsigned depth, logic [KEY_W-1:0] key, bit keyed);
      if (keyed && depth == 0) return ST_NOT_MARKED;
      if (key > depth) return ST_UNBALANCED;
      if (key < depth) return ST_RELEASED;
      return ST_OK;
    endfunction

    // Apply one accepted request and queue the response it must produce.
    function void note_request(logic [MODE_W-1:0] m, logic [WORD_W-1:0] n,
                               logic [KEY_W-1:0] k);
      status_t           st;
      logic [WORD_W-1:0] addr;
      logic [WORD_W-1:0] new_span;
      logic [KEY_W-1:0]  kout;
      alloc_result_t     r;
      st   = ST_OK;
      addr = '0;
      kout = '0;
      case (mode_t'(m))
        MODE_INIT: begin
          if (heap_cfg < MIN_HEAP_BYTES || heap_cfg < HEADER_BYTES) begin
            st = ST_NO_SPACE;
          end else begin
            total     = heap_cfg;
            low_ptr   = HEADER_BYTES;
            used      = HEADER_BYTES;
            span      = heap_cfg - HEADER_BYTES;
            top_depth = 0;
            bot_depth = 0;
          end
        end
        MODE_ALLOC_TOP: st = take_top(n, addr);
        MODE_ALLOC_BOT: st = take_bottom(n, addr);
        MODE_KEYED_TOP: begin
          st = key_status(top_depth, k, 1'b1);
          if (st == ST_OK) st = take_top(n, addr);
        end
        MODE_KEYED_BOT: begin
          st = key_status(bot_depth, k, 1'b1);
          if (st == ST_OK) st = take_bottom(n, addr);
        end
        MODE_MARK_TOP: begin
          if (top_depth < MARK_DEPTH) begin
            top_marks[top_depth] = low_ptr + span;
            top_depth++;
            kout = KEY_W'(top_depth);
          end else begin
            st = ST_STACK_FULL;
          end
        end
        MODE_MARK_BOT: begin
          if (bot_depth < MARK_DEPTH) begin
            bot_marks[bot_depth] = low_ptr;
            bot_depth++;
            kout = KEY_W'(bot_depth);
          end else begin
            st = ST_STACK_FULL;
          end
        end
        MODE_RELEASE_TOP: begin
          // An empty stack releases nothing and still reports success.
          if (top_depth != 0) begin
            st = key_status(top_depth, k, 1'b0);
            if (st == ST_OK) begin
              top_depth--;
              new_span = top_marks[top_depth] - low_ptr;
              used    -= new_span - span;
              span     = new_span;
            end
          end
        end
        MODE_RELEASE_BOT: begin
          if (bot_depth != 0) begin
            st = key_status(bot_depth, k, 1'b0);
            if (st == ST_OK) begin
              bot_depth--;
              new_span = low_ptr + span - bot_marks[bot_depth];
              used    -= new_span - span;
              low_ptr  = bot_marks[bot_depth];
              span     = new_span;
            end
          end
        end
        default: st = ST_NO_SPACE;
      endcase
      if (st != ST_OK) addr = '0;
      r.status  = st;
      r.address = addr;
      r.key_out = kout;
      r.used    = used;
      r.free    = total - used;
      owed_results.insert(owed_results.size(), r);
    endfunction

    // Compare one response transfer with the oldest owed response.
    function void check_result(logic [STATUS_W-1:0] status, logic [WORD_W-1:0] address,
                               logic [KEY_W-1:0] key_out, logic [WORD_W-1:0] used_b,
                               logic [WORD_W-1:0] free_b);
      alloc_result_t r;
      n_checked++;
      if (status < 8) status_seen[status]++;
      if (owed_results.size() == 0) begin
        $display("%0t: response with no request outstanding, status %0d", $time, status);
        n_errors++;
        return;
      end
      r = owed_results.pop_front();
      if (status !== r.status) begin
        $display("%0t: status expected %0d actual %0d", $time, r.status, status);
        n_errors++;
      end
      if (address !== r.address) begin
        $display("%0t: address expected %h actual %h", $time, r.address, address);
        n_errors++;
      end
      if (key_out !== r.key_out) begin
        $display("%0t: key_out expected %0d actual %0d", $time, r.key_out, key_out);
        n_errors++;
      end
      if (used_b !== r.used) begin
        $display("%0t: used_bytes expected %h actual %h", $time, r.used, used_b);
        n_errors++;
      end
      if (free_b !== r.free) begin
        $display("%0t: free_bytes expected %h actual %h", $time, r.free, free_b);
        n_errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [WORD_W-1:0] cfg_data;

  msa_req_if req_if ();
  msa_rsp_if rsp_if ();

  mark_release_stack_allocator i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .req      (req_if),
    .rsp      (rsp_if)
  );

  alloc_scoreboard sb;
  bit              idling;
  int unsigned     stall_left;
  int unsigned     n_sent;
  int unsigned     n_heaps;

  // Clock generation.
  always #(CYCLE / 2) clk = ~clk;

  // Response side: ready drops in random bursts while idling is enabled.
  initial begin
    rsp_if.ready = 1'b0;
    stall_left   = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else if (idling && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 8) - 1;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Every response transfer is checked at the edge on which it happens.
  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      sb.check_result(rsp_if.status, rsp_if.address, rsp_if.key_out,
                      rsp_if.used_bytes, rsp_if.free_bytes);
    end
  end

  // Hard limit on the length of the run.
  initial begin
    #(CYCLE * 400000);
    $display("tb_top failed");
    $finish;
  end

  // Drive one request and wait for its transfer; returns on a falling edge.
  task automatic send(input logic [MODE_W-1:0] m, input logic [WORD_W-1:0] n,
                      input logic [KEY_W-1:0] k);
    if (idling && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    req_if.valid         <= 1'b1;
    req_if.mode          <= m;
    req_if.request_bytes <= n;
    req_if.key_in        <= k;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    sb.note_request(m, n, k);
    n_sent++;
    @(negedge clk);
  endtask

  // Hold off new requests until every owed response has been transferred.
  task automatic drain();
    req_if.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write heap_size; only called once the block is idle.
  task automatic write_heap(input logic [WORD_W-1:0] v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.heap_cfg = v;
    n_heaps++;
  endtask

  function automatic logic [WORD_W-1:0] pick_bytes();
    case ($urandom_range(0, 11)) inside
      0:       return '0;
      [1:3]:   return $urandom_range(1, 64);
      [4:5]:   return $urandom_range(1, 1024);
      6:       return sb.span >> $urandom_range(0, 4);
      7:       return sb.span - $urandom_range(0, 24);
      [8:9]:   return $urandom;
      10:      return 32'hFFFF_FFF0 | $urandom_range(0, 15);
      default: return $urandom_range(1, 8192);
    endcase
  endfunction

  function automatic int unsigned depth_of(bit top);
    return top ? sb.top_depth : sb.bot_depth;
  endfunction

  // Mark one end, allocate under that mark, then usually release it again.
  task automatic run_frame();
    bit                top;
    int unsigned       n_alloc;
    logic [MODE_W-1:0] m_mark;
    logic [MODE_W-1:0] m_keyed;
    logic [MODE_W-1:0] m_rel;
    logic [KEY_W-1:0]  key;
    top     = 1'($urandom_range(0, 1));
    m_mark  = top ? MODE_MARK_TOP : MODE_MARK_BOT;
    m_keyed = top ? MODE_KEYED_TOP : MODE_KEYED_BOT;
    m_rel   = top ? MODE_RELEASE_TOP : MODE_RELEASE_BOT;
    send(m_mark, $urandom, KEY_W'($urandom_range(0, 31)));
    n_alloc = $urandom_range(1, 6);
    repeat (n_alloc) begin
      key = KEY_W'(depth_of(top));
      case ($urandom_range(0, 5)) inside
        [0:2]:   send(m_keyed, pick_bytes(), key);
        3:       send(m_keyed, pick_bytes(),
                      KEY_W'(key + ($urandom_range(0, 1) ? 1 : -1)));
        4:       send(MODE_ALLOC_TOP, pick_bytes(), KEY_W'($urandom_range(0, 31)));
        default: send(MODE_ALLOC_BOT, pick_bytes(), KEY_W'($urandom_range(0, 31)));
      endcase
    end
    key = KEY_W'(depth_of(top));
    case ($urandom_range(0, 7))
      0:       ;
      1:       send(m_rel, $urandom, KEY_W'(key + ($urandom_range(0, 1) ? 1 : -1)));
      default: send(m_rel, $urandom, key);
    endcase
  endtask

  // Fill one mark stack past its limit, then unwind it completely.
  task automatic run_fill();
    bit                top;
    logic [MODE_W-1:0] m_mark;
    logic [MODE_W-1:0] m_keyed;
    logic [MODE_W-1:0] m_rel;
    top     = 1'($urandom_range(0, 1));
    m_mark  = top ? MODE_MARK_TOP : MODE_MARK_BOT;
    m_keyed = top ? MODE_KEYED_TOP : MODE_KEYED_BOT;
    m_rel   = top ? MODE_RELEASE_TOP : MODE_RELEASE_BOT;
    while (depth_of(top) < MARK_DEPTH) begin
      send(m_mark, $urandom, KEY_W'($urandom_range(0, 31)));
    end
    send(m_mark, $urandom, KEY_W'($urandom_range(0, 31)));
    while (depth_of(top) > 0) begin
      if ($urandom_range(0, 2) == 0) begin
        send(m_keyed, $urandom_range(1, 200), KEY_W'(depth_of(top)));
      end
      send(m_rel, $urandom, KEY_W'(depth_of(top)));
    end
  endtask

  function automatic logic [WORD_W-1:0] heap_for_phase(int unsigned ph);
    case (ph)
      0:       return 1000;
      1:       return MIN_HEAP_BYTES;
      2:       return '0;
      3:       return 32'hFFFF_FFFF;
      4:       return MIN_HEAP_BYTES - 1;
      5:       return $urandom_range(MIN_HEAP_BYTES + 1, 9000);
      6:       return RESET_HEAP;
      default: return $urandom_range(300, 3000);
    endcase
  endfunction

  // Main stimulus.
  initial begin
    int unsigned start_count;
    int unsigned i;
    sb                   = new();
    clk                  = 1'b0;
    rst                  = 1'b1;
    cfg_we               = 1'b0;
    cfg_data             = '0;
    req_if.valid         = 1'b0;
    req_if.mode          = '0;
    req_if.request_bytes = '0;
    req_if.key_in        = '0;
    idling               = 1'b0;
    n_sent               = 0;
    n_heaps              = 0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: boundaries of the sizes, every operation and the key checks.
    idling = 1'b1;
    send(MODE_INIT, '0, '0);
    send(MODE_ALLOC_TOP, '0, '0);
    send(MODE_ALLOC_BOT, '0, '0);
    send(MODE_ALLOC_TOP, 1, '0);
    send(MODE_ALLOC_BOT, 1, '0);
    send(MODE_ALLOC_TOP, 32'hFFFF_FFFF, 5'h1F);
    send(MODE_ALLOC_BOT, 32'hFFFF_FFFF, 5'h1F);
    send(MODE_ALLOC_TOP, sb.span - 8, '0);
    send(MODE_KEYED_TOP, 64, 5'd0);
    send(MODE_KEYED_BOT, 64, 5'd1);
    send(MODE_RELEASE_TOP, '0, 5'd7);
    send(MODE_RELEASE_BOT, '0, 5'd0);
    send(MODE_MARK_TOP, '0, '0);
    send(MODE_MARK_BOT, '0, '0);
    send(MODE_KEYED_TOP, 100, 5'd1);
    send(MODE_KEYED_TOP, 100, 5'd2);
    send(MODE_KEYED_BOT, 33, 5'd0);
    send(MODE_KEYED_BOT, 33, 5'd1);
    send(MODE_RELEASE_TOP, '0, 5'h1F);
    send(MODE_RELEASE_TOP, '0, 5'd0);
    send(MODE_RELEASE_TOP, '0, 5'd1);
    send(MODE_RELEASE_BOT, '0, 5'd1);
    send(4'd9, 32'h5A5A_5A5A, 5'h0A);
    send(4'd15, 32'hFFFF_FFFF, 5'h1F);
    send(MODE_ALLOC_BOT, sb.span - BLOCK_BYTES, '0);
    send(MODE_ALLOC_TOP, 1, '0);

    // Random phases, each under its own heap_size; the last one without idling.
    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      drain();
      write_heap(heap_for_phase(ph));
      idling = (ph != PHASES - 1);
      send(MODE_INIT, $urandom, KEY_W'($urandom_range(0, 31)));
      start_count = n_sent;
      while (n_sent - start_count < PHASE_ITEMS) begin
        if (ph != PHASES - 1 && $urandom_range(0, 15) == 0) idling = !idling;
        if ($urandom_range(0, 39) == 0) drain();
        case ($urandom_range(0, 19)) inside
          [0:11]:  run_frame();
          12:      run_fill();
          [13:18]: send(MODE_W'($urandom_range(0, 15)), pick_bytes(),
                        KEY_W'($urandom_range(0, 31)));
          default: send(MODE_INIT, $urandom, KEY_W'($urandom_range(0, 31)));
        endcase
      end
    end

    // Let the last responses come out, then report.
    req_if.valid <= 1'b0;
    for (i = 0; i < 5000 && sb.pending() != 0; i++) @(negedge clk);
    if (sb.pending() != 0) begin
      $display("%0t: %0d responses never arrived", $time, sb.pending());
      sb.n_errors++;
    end
    repeat (8) @(negedge clk);
    $display("Covered %0d requests and %0d response transfers over %0d heap_size writes.",
             n_sent, sb.n_checked, n_heaps);
    $display("Statuses seen: ok %0d, no space %0d, full %0d, unbalanced %0d, %0s %0d, %0s %0d",
             sb.status_seen[ST_OK], sb.status_seen[ST_NO_SPACE],
             sb.status_seen[ST_STACK_FULL], sb.status_seen[ST_UNBALANCED],
             "released", sb.status_seen[ST_RELEASED],
             "not marked", sb.status_seen[ST_NOT_MARKED]);
    if (sb.n_errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

### sim.f
hdl/msa_pkg.sv
hdl/msa_ifs.sv
hdl/msa_ctrl.sv
hdl/msa_dp.sv
hdl/mark_release_stack_allocator.sv
tb/tb_top.sv
